[hw/rtl/csu_pkg.sv]
// ----------------------------------------------------------------------------
// csu_pkg: shared definitions of the counting semaphore unit
// Sizes, request codes, beat payload types and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package csu_pkg;

	// Sizing of the unit.
	localparam int NUM_SEMS   = 16;
	localparam int WAIT_DEPTH = 16;
	localparam int COUNT_BITS = 16;

	// Fixed field widths of the request and result beats.
	localparam int ACTION_W   = 2;
	localparam int SEM_ID_W   = 8;
	localparam int PID_W      = 4;
	localparam int INIT_W     = 16;
	localparam int NEW_ID_W   = 4;

	// Derived widths.
	localparam int ID_BITS    = $clog2(NUM_SEMS);
	localparam int FREE_BITS  = $clog2(NUM_SEMS + 1);
	localparam int HEAD_BITS  = $clog2(WAIT_DEPTH);
	localparam int FILL_BITS  = $clog2(WAIT_DEPTH + 1);
	localparam int ADDR_BITS  = $clog2(NUM_SEMS * WAIT_DEPTH);
	localparam int CMP_BITS   = (COUNT_BITS > INIT_W) ? COUNT_BITS : INIT_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Request codes.
	localparam logic [ACTION_W-1:0] ACT_GET  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WAIT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POST = 2'd2;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FILL_BITS-1:0]  fill_t;
	typedef logic [HEAD_BITS-1:0]  head_t;
	typedef logic [ID_BITS-1:0]    sem_idx_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SEM_ID_W-1:0] sem_id;
		logic [PID_W-1:0]    caller_pid;
		logic [INIT_W-1:0]   init_count;
	} req_t;

	typedef struct packed {
		logic [NEW_ID_W-1:0] new_sem_id;
		logic                get_failed;
		logic                caller_blocked;
		logic                woke_valid;
		logic [PID_W-1:0]    woke_pid;
		logic                bad_id;
		logic                overflow;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;    // capture the request beat
		logic rd;      // read the wait store at the queue head
		logic commit;  // update state and load the result register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic res_full;  // result register holds a beat not yet taken
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/csu_if.sv]
// ----------------------------------------------------------------------------
// csu_if: request and result channels of the counting semaphore unit
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface csu_req_if;
	logic          valid;
	logic          ready;
	csu_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface csu_rsp_if;
	logic          valid;
	logic          ready;
	csu_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/csu_ctrl.sv]
// ----------------------------------------------------------------------------
// csu_ctrl: request sequencer
// Steps each request through capture, wait store read and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module csu_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire logic             rsp_ready,
	input  wire csu_pkg::status_t status,
	output csu_pkg::cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	state_t state_q;

	// Commit waits until the result register can take the new beat.
	logic slot_free;
	assign slot_free = !status.res_full || rsp_ready;

	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		cmd.load   = req_valid && (state_q == ST_IDLE);
		cmd.rd     = (state_q == ST_READ);
		cmd.commit = (state_q == ST_EXEC) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/csu_datapath.sv]
// ----------------------------------------------------------------------------
// csu_datapath: semaphore state, wait store and result register
// Holds counts, queue pointers, the pid store and the allocation pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module csu_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire csu_pkg::cmd_t  cmd,
	output csu_pkg::status_t    status,
	input  wire csu_pkg::req_t  req_data,
	input  wire logic           rsp_ready,
	output logic                rsp_valid,
	output csu_pkg::rsp_t       rsp_data
);

	// Per-semaphore state, cleared at reset.
	csu_pkg::count_t count_q [csu_pkg::NUM_SEMS];
	csu_pkg::fill_t  fill_q  [csu_pkg::NUM_SEMS];
	csu_pkg::head_t  head_q  [csu_pkg::NUM_SEMS];
	logic [csu_pkg::FREE_BITS-1:0] free_q;

	// Queued pids of all semaphores; entries are only used after being written.
	logic [csu_pkg::PID_W-1:0] wait_mem [csu_pkg::NUM_SEMS * csu_pkg::WAIT_DEPTH];
	logic [csu_pkg::PID_W-1:0] rdata_q;

	csu_pkg::req_t req_q;
	csu_pkg::rsp_t res_q;
	logic          res_valid_q;

	csu_pkg::sem_idx_t id;
	logic              id_bad;
	csu_pkg::count_t   cur_count;
	csu_pkg::fill_t    cur_fill;
	csu_pkg::head_t    cur_head;
	logic [csu_pkg::FILL_BITS:0] tail_sum;
	csu_pkg::head_t    tail;
	csu_pkg::head_t    head_inc;
	csu_pkg::addr_t    rd_addr;
	csu_pkg::addr_t    wr_addr;
	logic              pool_empty;
	csu_pkg::sem_idx_t alloc_id;
	logic              init_wide;

	csu_pkg::rsp_t     res_d;
	csu_pkg::sem_idx_t widx;
	logic              upd_count;
	csu_pkg::count_t   count_d;
	logic              upd_queue;
	csu_pkg::fill_t    fill_d;
	csu_pkg::head_t    head_d;
	logic              enq;
	logic              alloc;

	assign id        = req_q.sem_id[csu_pkg::ID_BITS-1:0];
	assign id_bad    = req_q.sem_id >= csu_pkg::SEM_ID_W'(csu_pkg::NUM_SEMS);
	assign cur_count = count_q[id];
	assign cur_fill  = fill_q[id];
	assign cur_head  = head_q[id];

	// Tail slot: head plus fill stays below twice the depth, so one subtract wraps it.
	assign tail_sum = (csu_pkg::FILL_BITS+1)'(cur_head) + (csu_pkg::FILL_BITS+1)'(cur_fill);
	assign tail     = (tail_sum >= (csu_pkg::FILL_BITS+1)'(csu_pkg::WAIT_DEPTH))
		? csu_pkg::HEAD_BITS'(tail_sum - (csu_pkg::FILL_BITS+1)'(csu_pkg::WAIT_DEPTH))
		: csu_pkg::HEAD_BITS'(tail_sum);
	assign head_inc = (cur_head == csu_pkg::HEAD_BITS'(csu_pkg::WAIT_DEPTH - 1))
		? '0 : cur_head + 1'b1;

	assign rd_addr = csu_pkg::ADDR_BITS'(id) * csu_pkg::ADDR_BITS'(csu_pkg::WAIT_DEPTH)
		+ csu_pkg::ADDR_BITS'(cur_head);
	assign wr_addr = csu_pkg::ADDR_BITS'(id) * csu_pkg::ADDR_BITS'(csu_pkg::WAIT_DEPTH)
		+ csu_pkg::ADDR_BITS'(tail);

	assign pool_empty = free_q >= csu_pkg::FREE_BITS'(csu_pkg::NUM_SEMS);
	assign alloc_id   = free_q[csu_pkg::ID_BITS-1:0];
	assign init_wide  = csu_pkg::CMP_BITS'(req_q.init_count)
		> csu_pkg::CMP_BITS'(csu_pkg::COUNT_MAX);

	always_comb begin
		res_d     = '0;
		widx      = id;
		upd_count = 1'b0;
		count_d   = cur_count;
		upd_queue = 1'b0;
		fill_d    = cur_fill;
		head_d    = cur_head;
		enq       = 1'b0;
		alloc     = 1'b0;
		unique case (req_q.action)
			csu_pkg::ACT_GET: begin
				if (pool_empty) begin
					res_d.get_failed = 1'b1;
				end else begin
					alloc            = 1'b1;
					widx             = alloc_id;
					res_d.new_sem_id = csu_pkg::NEW_ID_W'(alloc_id);
					upd_queue        = 1'b1;
					fill_d           = '0;
					head_d           = '0;
					upd_count        = 1'b1;
					if (init_wide) begin
						count_d        = csu_pkg::COUNT_MAX;
						res_d.overflow = 1'b1;
					end else begin
						count_d = csu_pkg::COUNT_BITS'(req_q.init_count);
					end
				end
			end
			csu_pkg::ACT_WAIT: begin
				if (id_bad) begin
					res_d.bad_id = 1'b1;
				end else if (cur_count != '0) begin
					upd_count = 1'b1;
					count_d   = cur_count - 1'b1;
				end else if (cur_fill >= csu_pkg::FILL_BITS'(csu_pkg::WAIT_DEPTH)) begin
					res_d.overflow = 1'b1;
				end else begin
					enq                  = 1'b1;
					upd_queue            = 1'b1;
					fill_d               = cur_fill + 1'b1;
					res_d.caller_blocked = 1'b1;
				end
			end
			csu_pkg::ACT_POST: begin
				if (id_bad) begin
					res_d.bad_id = 1'b1;
				end else if (cur_fill != '0) begin
					upd_queue        = 1'b1;
					fill_d           = cur_fill - 1'b1;
					head_d           = head_inc;
					res_d.woke_valid = 1'b1;
					res_d.woke_pid   = rdata_q;
				end else if (cur_count == csu_pkg::COUNT_MAX) begin
					res_d.overflow = 1'b1;
				end else begin
					upd_count = 1'b1;
					count_d   = cur_count + 1'b1;
				end
			end
			default: begin
				// Unknown request: no state change, all-zero result.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csu_pkg::NUM_SEMS; i++) begin
				count_q[i] <= '0;
				fill_q[i]  <= '0;
				head_q[i]  <= '0;
			end
			free_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (upd_count) count_q[widx] <= count_d;
				if (upd_queue) begin
					fill_q[widx] <= fill_d;
					head_q[widx] <= head_d;
				end
				if (alloc) free_q <= free_q + 1'b1;
				res_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_data;
		if (cmd.rd) rdata_q <= wait_mem[rd_addr];
		if (cmd.commit && enq) wait_mem[wr_addr] <= req_q.caller_pid;
		if (cmd.commit) res_q <= res_d;
	end

	assign status.res_full = res_valid_q;
	assign rsp_valid       = res_valid_q;
	assign rsp_data        = res_q;

endmodule

`default_nettype wire

[hw/rtl/counting_semaphore_unit.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_unit: counting semaphores with per-semaphore FIFO waiters
// Serves get, wait and post requests and returns one result beat per request.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                          Handshake
// req      in   action, sem_id, caller_pid, init_count           valid/ready
// rsp      out  new_sem_id, get_failed, caller_blocked,          valid/ready
//               woke_valid, woke_pid, bad_id, overflow
//
// Each request passes through capture, a registered read of the wait store at the
// queue head, then the state update and result load. The result register sits
// apart from the sequencer, so the next beat can be taken while an earlier result
// waits; a commit stalls only while that register is full and rsp.ready is low.
// Reset clears counts, queue pointers and the allocation pointer; the wait store
// is not cleared, as a slot is only used once written.
`default_nettype none

module counting_semaphore_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	csu_req_if.sink    req,
	csu_rsp_if.source  rsp
);

	csu_pkg::cmd_t    cmd;
	csu_pkg::status_t status;

	// Sequencer: walks a request through capture, store read and commit.
	csu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: semaphore state, the pid store and the result register.
	csu_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data)
	);

	// A captured request always goes on to the store read next cycle, and no new
	// beat may be taken while it is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (cmd.rd && !req.ready))
		else $error("captured request did not proceed to the store read");

	// A commit always presents a result beat in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("commit did not produce a result beat");

	// A result reports at most one of failure, blocking, wake-up or a bad id.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.data.get_failed, rsp.data.caller_blocked,
			rsp.data.woke_valid, rsp.data.bad_id}))
		else $error("result carries conflicting outcome flags");

	// A woken pid is only reported together with a wake-up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.woke_valid) |-> (rsp.data.woke_pid == '0))
		else $error("woke_pid set without a wake-up");

endmodule

`default_nettype wire

[sim/csu_outcome_checker.sv]
// ----------------------------------------------------------------------------
// csu_outcome_checker: result checking for the counting semaphore unit
// Watches both channels, keeps its own copy of the semaphore state and compares
// every result beat with the outcome predicted for the oldest request.
// ----------------------------------------------------------------------------

module csu_outcome_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	csu_req_if        req_mon,
	csu_rsp_if        rsp_mon,
	output int        fail_count,
	output int        requests_seen,
	output int        results_seen
);

	csu_pkg::count_t                sem_level  [csu_pkg::NUM_SEMS];
	csu_pkg::fill_t                 queue_fill [csu_pkg::NUM_SEMS];
	csu_pkg::head_t                 queue_head [csu_pkg::NUM_SEMS];
	logic [csu_pkg::PID_W-1:0]      waiter_pid [csu_pkg::NUM_SEMS*csu_pkg::WAIT_DEPTH];
	logic [csu_pkg::FREE_BITS-1:0]  alloc_next;

	csu_pkg::rsp_t outcome_q [$];
	csu_pkg::rsp_t want;
	int            errs;

	// Serves one request against the shadow state and returns its outcome.
	function automatic csu_pkg::rsp_t serve_request(csu_pkg::req_t r);
		csu_pkg::rsp_t     o;
		csu_pkg::sem_idx_t s;
		int                pos;
		o = '0;
		case (r.action) inside
			csu_pkg::ACT_GET: begin
				if (alloc_next >= csu_pkg::NUM_SEMS) begin
					o.get_failed = 1'b1;
				end else begin
					s = csu_pkg::sem_idx_t'(alloc_next);
					o.new_sem_id = csu_pkg::NEW_ID_W'(alloc_next);
					alloc_next = alloc_next + 1'b1;
					queue_fill[s] = '0;
					queue_head[s] = '0;
					if (csu_pkg::CMP_BITS'(r.init_count)
						> csu_pkg::CMP_BITS'(csu_pkg::COUNT_MAX)) begin
						sem_level[s] = csu_pkg::COUNT_MAX;
						o.overflow = 1'b1;
					end else begin
						sem_level[s] = csu_pkg::count_t'(r.init_count);
					end
				end
			end
			csu_pkg::ACT_WAIT, csu_pkg::ACT_POST: begin
				if (r.sem_id >= csu_pkg::NUM_SEMS) begin
					o.bad_id = 1'b1;
				end else begin
					s = csu_pkg::sem_idx_t'(r.sem_id);
					if (r.action == csu_pkg::ACT_WAIT) begin
						if (sem_level[s] != '0) begin
							sem_level[s] = sem_level[s] - 1'b1;
						end else if (queue_fill[s] >= csu_pkg::WAIT_DEPTH) begin
							o.overflow = 1'b1;
						end else begin
							pos = (int'(queue_head[s]) + int'(queue_fill[s]))
								% csu_pkg::WAIT_DEPTH;
							waiter_pid[int'(s)*csu_pkg::WAIT_DEPTH + pos] = r.caller_pid;
							queue_fill[s] = queue_fill[s] + 1'b1;
							o.caller_blocked = 1'b1;
						end
					end else begin
						if (queue_fill[s] != '0) begin
							pos = int'(queue_head[s]) % csu_pkg::WAIT_DEPTH;
							o.woke_pid = waiter_pid[int'(s)*csu_pkg::WAIT_DEPTH + pos];
							o.woke_valid = 1'b1;
							queue_head[s] = csu_pkg::head_t'((pos + 1) % csu_pkg::WAIT_DEPTH);
							queue_fill[s] = queue_fill[s] - 1'b1;
						end else if (sem_level[s] == csu_pkg::COUNT_MAX) begin
							o.overflow = 1'b1;
						end else begin
							sem_level[s] = sem_level[s] + 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic string show(csu_pkg::rsp_t r);
		return $sformatf("id=%0d fail=%0b blk=%0b wv=%0b wpid=%0d bad=%0b ovf=%0b",
			r.new_sem_id, r.get_failed, r.caller_blocked, r.woke_valid, r.woke_pid,
			r.bad_id, r.overflow);
	endfunction

	function automatic string differing_fields(csu_pkg::rsp_t w, csu_pkg::rsp_t g);
		string s;
		s = "";
		if (w.new_sem_id !== g.new_sem_id)         s = {s, " new_sem_id"};
		if (w.get_failed !== g.get_failed)         s = {s, " get_failed"};
		if (w.caller_blocked !== g.caller_blocked) s = {s, " caller_blocked"};
		if (w.woke_valid !== g.woke_valid)         s = {s, " woke_valid"};
		if (w.woke_pid !== g.woke_pid)             s = {s, " woke_pid"};
		if (w.bad_id !== g.bad_id)                 s = {s, " bad_id"};
		if (w.overflow !== g.overflow)             s = {s, " overflow"};
		return s;
	endfunction

	task automatic log_failure(string what);
		errs++;
		if (errs <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	// Result beats are matched before request beats are queued, so a result
	// seen at the same edge as a new request belongs to an older one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (sem_level[i]) begin
				sem_level[i] = '0;
				queue_fill[i] = '0;
				queue_head[i] = '0;
			end
			alloc_next = '0;
			outcome_q.delete();
			errs = 0;
			fail_count <= 0;
			requests_seen <= 0;
			results_seen <= 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (outcome_q.size() == 0) begin
					log_failure({"result beat with no request pending: ", show(rsp_mon.data)});
				end else begin
					want = outcome_q.pop_front();
					if (differing_fields(want, rsp_mon.data) != "")
						log_failure({"mismatch in", differing_fields(want, rsp_mon.data),
							": expected ", show(want), ", got ", show(rsp_mon.data)});
				end
				results_seen <= results_seen + 1;
			end
			if (req_mon.valid && req_mon.ready) begin
				outcome_q.push_back(serve_request(req_mon.data));
				requests_seen <= requests_seen + 1;
			end
			fail_count <= errs;
		end
	end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression of the counting semaphore unit
// Drives directed and random get, wait and post requests with bursty traffic
// and a stalling receiver; the outcome checker judges every result beat.
// ----------------------------------------------------------------------------

module testbench;

	// Cycle limit, set with a wide margin over the slowest legal run (about 1.1k
	// requests plus gaps, stalls and two long receiver hold-offs).
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1050;

	// The request code that the unit does not define.
	localparam logic [csu_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_MASK} rx_mode_t;
	typedef enum int {SEQ_WAITS, SEQ_POSTS, SEQ_MIXED, SEQ_NOISE, SEQ_DRAIN} seq_kind_t;

	logic clk;
	logic arst_n;

	csu_req_if req_ch ();
	csu_rsp_if rsp_ch ();

	int chk_fails;
	int chk_requests;
	int chk_results;

	counting_semaphore_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	csu_outcome_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_mon       (req_ch),
		.rsp_mon       (rsp_ch),
		.fail_count    (chk_fails),
		.requests_seen (chk_requests),
		.results_seen  (chk_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Beats left in the current burst. When it runs out the sender may drop
	// valid for a random gap before the next burst starts.
	int burst_left;
	// Requests that actually exercise the unit (gets and in-range waits and
	// posts); ignored beats do not count toward the item target.
	int served_items;
	int gets_sent;

	// Noise beats draw the action from the whole field, unused code included.
	function automatic logic [csu_pkg::ACTION_W-1:0] random_action();
		return csu_pkg::ACTION_W'($urandom_range(0, 3));
	endfunction

	// Offers one request beat and returns at the edge where it was taken.
	// The valid line is only lowered when a real gap follows, so a back-to-back
	// beat never sees valid dropped and raised in the same time step.
	task automatic offer_request(input logic [csu_pkg::ACTION_W-1:0] act, input int id,
		input int pid, input int init);
		csu_pkg::req_t beat;
		int            gap;
		beat.action     = act;
		beat.sem_id     = csu_pkg::SEM_ID_W'(id);
		beat.caller_pid = csu_pkg::PID_W'(pid);
		beat.init_count = csu_pkg::INIT_W'(init);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= beat;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		if (act == csu_pkg::ACT_GET)
			gets_sent++;
		if (act == csu_pkg::ACT_GET || ((act == csu_pkg::ACT_WAIT || act == csu_pkg::ACT_POST)
			&& id < csu_pkg::NUM_SEMS))
			served_items++;
	endtask

	// Holds the sender off until every request so far has its result back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_results < chk_requests);
		burst_left = 0;
	endtask

	initial begin
		seq_kind_t kind;
		int        pick;
		int        sem;
		int        run;
		int        init;

		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		burst_left   = 0;
		served_items = 0;
		gets_sent    = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. Semaphore 3 is used before it is ever allocated: two
		// callers block, are woken in order, and the spare post leaves a count
		// of one that the next wait consumes.
		offer_request(csu_pkg::ACT_WAIT, 3, 5, 0);
		offer_request(csu_pkg::ACT_WAIT, 3, 10, 0);
		offer_request(csu_pkg::ACT_POST, 3, 0, 0);
		offer_request(csu_pkg::ACT_POST, 3, 0, 0);
		offer_request(csu_pkg::ACT_POST, 3, 0, 0);
		offer_request(csu_pkg::ACT_WAIT, 3, 1, 0);
		// Ids just past the range and at the top of the field are rejected.
		offer_request(csu_pkg::ACT_WAIT, csu_pkg::NUM_SEMS, 15, 16'hFFFF);
		offer_request(csu_pkg::ACT_POST, 255, 0, 0);
		// The unused action code with every other field at both extremes.
		offer_request(ACT_UNUSED, 255, 15, 16'hFFFF);
		offer_request(ACT_UNUSED, 0, 0, 0);
		// First id gets the largest count; a post there must saturate.
		offer_request(csu_pkg::ACT_GET, 0, 0, 16'hFFFF);
		offer_request(csu_pkg::ACT_POST, 0, 0, 0);
		offer_request(csu_pkg::ACT_WAIT, 0, 0, 0);
		offer_request(csu_pkg::ACT_POST, 0, 9, 0);
		// Second id starts empty, so its first waiter blocks at once.
		offer_request(csu_pkg::ACT_GET, 0, 0, 0);
		offer_request(csu_pkg::ACT_WAIT, 1, 15, 0);
		offer_request(csu_pkg::ACT_POST, 1, 0, 0);
		// Highest in-range id, never allocated yet.
		offer_request(csu_pkg::ACT_WAIT, csu_pkg::NUM_SEMS-1, 7, 16'h5A5A);
		offer_request(csu_pkg::ACT_POST, csu_pkg::NUM_SEMS-1, 8, 16'hA5A5);
		drain_results();

		// Random part: runs of waits or posts on one semaphore push its queue
		// toward full and empty again, gets come often until the pool is used
		// up, and a little noise mixes in bad ids and the unused action code.
		while (served_items < ITEM_TARGET) begin
			sem = $urandom_range(0, csu_pkg::NUM_SEMS-1);
			run = $urandom_range(1, 20);
			if ($urandom_range(0, (gets_sent < csu_pkg::NUM_SEMS + 4) ? 3 : 24) == 0) begin
				case ($urandom_range(0, 3))
					0:       init = 0;
					1:       init = $urandom_range(1, 3);
					2:       init = $urandom_range(0, 16'hFFFF);
					default: init = 16'hFFFF - $urandom_range(0, 1);
				endcase
				offer_request(csu_pkg::ACT_GET, $urandom_range(0, 255),
					$urandom_range(0, 15), init);
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 6)
					kind = SEQ_WAITS;
				else if (pick < 12)
					kind = SEQ_POSTS;
				else if (pick < 16)
					kind = SEQ_MIXED;
				else if (pick < 19)
					kind = SEQ_NOISE;
				else
					kind = SEQ_DRAIN;
				case (kind)
					SEQ_WAITS: begin
						repeat (run)
							offer_request(csu_pkg::ACT_WAIT, sem, $urandom_range(0, 15),
								$urandom_range(0, 16'hFFFF));
					end
					SEQ_POSTS: begin
						repeat (run)
							offer_request(csu_pkg::ACT_POST, sem, $urandom_range(0, 15),
								$urandom_range(0, 16'hFFFF));
					end
					SEQ_MIXED: begin
						repeat (run)
							offer_request($urandom_range(0, 1) ? csu_pkg::ACT_WAIT
								: csu_pkg::ACT_POST, sem,
								$urandom_range(0, 15), $urandom_range(0, 16'hFFFF));
					end
					SEQ_NOISE: begin
						repeat ($urandom_range(1, 5))
							offer_request(random_action(), $urandom_range(0, 255),
								$urandom_range(0, 15), $urandom_range(0, 16'hFFFF));
					end
					default: drain_results();
				endcase
			end
		end

		// All stimulus is in. Wait for the remaining results, then let the clock run
		// on so that any stray beat would show.
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_results < chk_requests);
		repeat (20) @(posedge clk);
		if (chk_fails == 0 && chk_results == chk_requests) begin
			$display("counting_semaphore_unit regression: pass");
		end else begin
			$display("counting_semaphore_unit regression: fail");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------------

	// The receiver switches between randomly chosen stall patterns, including
	// stretches where it never stalls. Twice in the run it holds
	// ready low for a long stretch while the sender keeps offering, which
	// fills the result register and backs the unit up onto its input.
	int       hold_left;
	int       next_hold_at;
	int       mode_left;
	rx_mode_t stall_mode;
	logic [7:0] stall_mask;

	initial begin
		rsp_ch.ready = 1'b0;
		hold_left    = 0;
		next_hold_at = 250;
		mode_left    = 0;
		stall_mode   = RX_ALWAYS;
		stall_mask   = 8'hFF;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && chk_requests >= next_hold_at && next_hold_at < 1000) begin
				hold_left = 200;
				next_hold_at += 500;
			end
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 120);
				stall_mask = 8'($urandom);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					RX_ALWAYS: rsp_ch.ready <= 1'b1;
					RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
					default: begin
						rsp_ch.ready <= stall_mask[0];
						stall_mask = {stall_mask[0], stall_mask[7:1]};
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("counting_semaphore_unit regression: fail");
		$finish;
	end

endmodule
